/* rtl/cwstk_pkg.sv */
// Shared widths, command codes and types for the circular wrapping stack.
`default_nettype none

package cwstk_pkg;

	localparam int DATA_W  = 32;
	localparam int CMD_W   = 3;
	localparam int OFF_W   = 6;
	localparam int DEPTH_W = 6;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [OFF_W-1:0]         offset_t;
	typedef logic [DEPTH_W-1:0]       depth_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_DUP   = 3'd3,
		CMD_SWAP  = 3'd4,
		CMD_QUERY = 3'd5
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/cwstk_in_if.sv */
// Command channel of the circular wrapping stack.
`default_nettype none

interface cwstk_in_if;

	logic                          valid;
	logic                          ready;
	logic [cwstk_pkg::CMD_W-1:0]   command;
	cwstk_pkg::word_t              push_value;
	cwstk_pkg::offset_t            peek_offset;

	modport source (output valid, output command, output push_value, output peek_offset,
		input ready);
	modport sink (input valid, input command, input push_value, input peek_offset,
		output ready);

endinterface

`default_nettype wire

/* rtl/cwstk_out_if.sv */
// Result channel of the circular wrapping stack.
`default_nettype none

interface cwstk_out_if;

	logic               valid;
	logic               ready;
	cwstk_pkg::word_t   read_data;
	cwstk_pkg::depth_t  depth_count;
	logic               underflow;

	modport source (output valid, output read_data, output depth_count, output underflow,
		input ready);
	modport sink (input valid, input read_data, input depth_count, input underflow,
		output ready);

endinterface

`default_nettype wire

/* rtl/circular_wrapping_stack_unit.sv */
// Circular wrapping stack: a ring of signed words served one command per beat.
//
// The req channel carries one command per beat (push, pop, peek, dup, swap or depth
// query) and the rsp channel returns exactly one result beat for each, in order.
// The two entries nearest the top are held in registers; the rest of the ring sits
// in a memory with one write and one registered read port, so a new beat is
// accepted in every cycle unless the ring is being cleared or rsp stalls.
// A result passes through the execute stage and then the output register: the
// accepting edge loads the execute stage, where a memory read for peek or pop
// lands, and the output register loads from it once it is empty or rsp takes its beat.
// Sustained throughput is one beat per cycle while rsp does not stall.
// After reset the block sweeps the ring memory to zero, one entry per cycle;
// req.ready stays low during that sweep.
// When the receiver stalls, the finished result waits in the output register and one
// more command is still taken into the execute stage; after that req.ready drops
// until rsp accepts a beat.
`default_nettype none

module circular_wrapping_stack_unit #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	cwstk_in_if.sink     req,
	cwstk_out_if.source  rsp
);

	localparam int PTR_W = $clog2(ENTRIES);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(ENTRIES - 1);
	localparam logic [PTR_W:0]   SPAN = (PTR_W + 1)'(ENTRIES);
	localparam int OFF_N = 1 << cwstk_pkg::OFF_W;

	cwstk_pkg::word_t ring_q [ENTRIES];
	cwstk_pkg::word_t rd_q;

	logic [PTR_W-1:0] top_q;
	logic [PTR_W-1:0] depth_q;
	cwstk_pkg::word_t c0_q;
	cwstk_pkg::word_t c1_q;
	logic             c1_mem_q;
	logic             clearing_q;
	logic [PTR_W-1:0] clr_cnt_q;

	logic               valid_s1;
	cwstk_pkg::word_t   data_s1;
	logic               mem_s1;
	cwstk_pkg::depth_t  depth_s1;
	logic               uf_s1;

	logic               out_valid_q;
	cwstk_pkg::word_t   out_data_q;
	cwstk_pkg::depth_t  out_depth_q;
	logic               out_uf_q;

	logic             acc;
	logic             s1_adv;
	cwstk_pkg::word_t c1_cur;
	logic [PTR_W-1:0] top_inc;
	logic [PTR_W-1:0] top_dec;
	logic [PTR_W-1:0] top_dec2;
	logic [PTR_W-1:0] offm;
	logic [PTR_W:0]   peek_sum;
	logic [PTR_W-1:0] peek_addr;

	logic [PTR_W-1:0] top_nx;
	logic [PTR_W-1:0] depth_nx;
	cwstk_pkg::word_t c0_nx;
	cwstk_pkg::word_t c1_nx;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	cwstk_pkg::word_t wr_data;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	cwstk_pkg::word_t res_data;
	logic             res_mem;
	logic             res_uf;

	logic             mem_we;
	logic [PTR_W-1:0] mem_wa;
	cwstk_pkg::word_t mem_wd;
	logic             mem_re;

	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clearing_q && (!valid_s1 || s1_adv);
	assign acc       = req.valid && req.ready;

	assign c1_cur   = c1_mem_q ? rd_q : c1_q;
	assign top_inc  = (top_q == LAST) ? '0 : top_q + PTR_W'(1);
	assign top_dec  = (top_q == '0) ? LAST : top_q - PTR_W'(1);
	assign top_dec2 = (top_dec == '0) ? LAST : top_dec - PTR_W'(1);

	always_comb begin
		offm = '0;
		for (int i = 0; i < OFF_N; i++) begin
			if (req.peek_offset == cwstk_pkg::OFF_W'(i)) begin
				offm = PTR_W'(i % ENTRIES);
			end
		end
	end

	assign peek_sum  = {1'b0, top_q} + SPAN - {1'b0, offm};
	assign peek_addr = (peek_sum >= SPAN) ? PTR_W'(peek_sum - SPAN) : PTR_W'(peek_sum);

	always_comb begin
		top_nx   = top_q;
		depth_nx = depth_q;
		c0_nx    = c0_q;
		c1_nx    = c1_cur;
		wr_en    = 1'b0;
		wr_addr  = top_dec;
		wr_data  = c1_cur;
		rd_en    = 1'b0;
		rd_addr  = top_dec2;
		res_data = '0;
		res_mem  = 1'b0;
		res_uf   = 1'b0;
		unique case (req.command)
			cwstk_pkg::CMD_PUSH: begin
				top_nx = top_inc;
				c0_nx  = req.push_value;
				c1_nx  = c0_q;
				wr_en  = 1'b1;
				if (depth_q != LAST) begin
					depth_nx = depth_q + PTR_W'(1);
				end
			end
			cwstk_pkg::CMD_POP: begin
				res_data = c0_q;
				top_nx   = top_dec;
				c0_nx    = c1_cur;
				wr_en    = 1'b1;
				wr_addr  = top_q;
				wr_data  = '0;
				rd_en    = 1'b1;
				if (depth_q == '0) begin
					res_uf = 1'b1;
				end else begin
					depth_nx = depth_q - PTR_W'(1);
				end
			end
			cwstk_pkg::CMD_PEEK: begin
				if (offm == '0) begin
					res_data = c0_q;
				end else if (offm == PTR_W'(1)) begin
					res_data = c1_cur;
				end else begin
					rd_en   = 1'b1;
					rd_addr = peek_addr;
					res_mem = 1'b1;
				end
			end
			cwstk_pkg::CMD_DUP: begin
				top_nx = top_inc;
				c1_nx  = c0_q;
				wr_en  = 1'b1;
				if (depth_q != LAST) begin
					depth_nx = depth_q + PTR_W'(1);
				end
			end
			cwstk_pkg::CMD_SWAP: begin
				c0_nx = c1_cur;
				c1_nx = c0_q;
			end
			default: begin
			end
		endcase
	end

	assign mem_we = clearing_q || (acc && wr_en);
	assign mem_wa = clearing_q ? clr_cnt_q : wr_addr;
	assign mem_wd = clearing_q ? '0 : wr_data;
	assign mem_re = acc && rd_en;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= (mem_we && (mem_wa == rd_addr)) ? mem_wd : ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + PTR_W'(1);
			if (clr_cnt_q == LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= LAST;
			depth_q  <= '0;
			c0_q     <= '0;
			c1_q     <= '0;
			c1_mem_q <= 1'b0;
		end else if (acc) begin
			top_q    <= top_nx;
			depth_q  <= depth_nx;
			c0_q     <= c0_nx;
			c1_q     <= c1_nx;
			c1_mem_q <= (req.command == cwstk_pkg::CMD_POP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_s1  <= res_data;
			mem_s1   <= res_mem;
			depth_s1 <= cwstk_pkg::DEPTH_W'(depth_nx);
			uf_s1    <= res_uf;
		end
		if (s1_adv) begin
			out_data_q  <= mem_s1 ? rd_q : data_s1;
			out_depth_q <= depth_s1;
			out_uf_q    <= uf_s1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = out_data_q;
	assign rsp.depth_count = out_depth_q;
	assign rsp.underflow   = out_uf_q;

	a_pop_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.command == cwstk_pkg::CMD_POP && depth_q == '0)
		|=> (uf_s1 && depth_q == '0))
		else $error("pop at zero depth did not raise underflow");

	a_c1_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(c1_mem_q) |-> $past(acc && req.command == cwstk_pkg::CMD_POP))
		else $error("second cache entry taken from memory without a pop");

	a_peek_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mem_s1 && !s1_adv) |=> $stable(rd_q))
		else $error("memory read data changed under a stalled peek");

	a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!acc && !valid_s1 && depth_q == '0))
		else $error("command taken while the ring is being cleared");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= LAST)
		else $error("tracked depth beyond ring size");

endmodule

`default_nettype wire

/* verif/circular_wrapping_stack_unit_test.sv */
// Self-checking testbench for the circular wrapping stack, with directed and random beats.
`timescale 1ns / 1ps

module circular_wrapping_stack_unit_test;

	localparam logic [cwstk_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [cwstk_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam int RANDOM_BEATS = 450;
	localparam int HOLD_AT      = 320;
	localparam int HOLD_CYCLES  = 300;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [cwstk_pkg::CMD_W-1:0] command;
		cwstk_pkg::word_t            push_value;
		cwstk_pkg::offset_t          peek_offset;
	} stack_cmd_t;

	typedef struct packed {
		cwstk_pkg::word_t  read_data;
		cwstk_pkg::depth_t depth_count;
		logic              underflow;
	} stack_result_t;

	typedef struct {
		stack_cmd_t    beat;
		bit            typed;
		stack_result_t want;
	} directed_row_t;

	typedef enum {MIX_EVEN, MIX_PUSHES, MIX_POPS} cmd_mix_t;

	logic clk = 1'b0;
	logic arst_n;

	cwstk_in_if  req_ch ();
	cwstk_out_if rsp_ch ();

	circular_wrapping_stack_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	cwstk_pkg::word_t   model_ring [64];
	cwstk_pkg::offset_t model_top;
	cwstk_pkg::depth_t  model_depth;
	stack_result_t      due_results [$];
	directed_row_t      directed_rows [$];
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 hold_remaining = 0;
	bit                 hold_done = 1'b0;
	bit                 steady_flow = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic stack_result_t predict_stack_result(stack_cmd_t c);
		stack_result_t      r;
		cwstk_pkg::offset_t idx;
		cwstk_pkg::word_t   held;
		r = '0;
		case (c.command)
			cwstk_pkg::CMD_PUSH: begin
				model_top = model_top + cwstk_pkg::offset_t'(1);
				model_ring[model_top] = c.push_value;
				if (model_depth != '1) model_depth = model_depth + cwstk_pkg::depth_t'(1);
			end
			cwstk_pkg::CMD_POP: begin
				r.read_data = model_ring[model_top];
				model_ring[model_top] = '0;
				model_top = model_top - cwstk_pkg::offset_t'(1);
				if (model_depth == '0) r.underflow = 1'b1;
				else model_depth = model_depth - cwstk_pkg::depth_t'(1);
			end
			cwstk_pkg::CMD_PEEK: begin
				idx = model_top - c.peek_offset;
				r.read_data = model_ring[idx];
			end
			cwstk_pkg::CMD_DUP: begin
				idx = model_top;
				model_top = model_top + cwstk_pkg::offset_t'(1);
				model_ring[model_top] = model_ring[idx];
				if (model_depth != '1) model_depth = model_depth + cwstk_pkg::depth_t'(1);
			end
			cwstk_pkg::CMD_SWAP: begin
				idx = model_top - cwstk_pkg::offset_t'(1);
				held = model_ring[model_top];
				model_ring[model_top] = model_ring[idx];
				model_ring[idx] = held;
			end
			default: begin
			end
		endcase
		r.depth_count = model_depth;
		return r;
	endfunction

	function automatic cwstk_pkg::word_t random_word();
		case ($urandom_range(7))
			0: return cwstk_pkg::word_t'(32'h7FFF_FFFF);
			1: return cwstk_pkg::word_t'(32'h8000_0000);
			default: return cwstk_pkg::word_t'($urandom);
		endcase
	endfunction

	function automatic logic [cwstk_pkg::CMD_W-1:0] pick_command(cmd_mix_t mix);
		int roll;
		roll = $urandom_range(99);
		case (mix)
			MIX_PUSHES: begin
				if (roll < 60) return cwstk_pkg::CMD_PUSH;
				if (roll < 75) return cwstk_pkg::CMD_DUP;
				if (roll < 85) return cwstk_pkg::CMD_PEEK;
				if (roll < 90) return cwstk_pkg::CMD_SWAP;
				if (roll < 95) return cwstk_pkg::CMD_QUERY;
				return cwstk_pkg::CMD_POP;
			end
			MIX_POPS: begin
				if (roll < 60) return cwstk_pkg::CMD_POP;
				if (roll < 75) return cwstk_pkg::CMD_PEEK;
				if (roll < 85) return cwstk_pkg::CMD_PUSH;
				if (roll < 90) return cwstk_pkg::CMD_SWAP;
				if (roll < 95) return cwstk_pkg::CMD_QUERY;
				return cwstk_pkg::CMD_DUP;
			end
			default: begin
				if (roll < 2) return CMD_SPARE_6;
				if (roll < 4) return CMD_SPARE_7;
				return cwstk_pkg::CMD_W'($urandom_range(5));
			end
		endcase
	endfunction

	task automatic add_row(input logic [cwstk_pkg::CMD_W-1:0] c, input logic [31:0] v,
			input cwstk_pkg::offset_t o, input bit typed, input logic [31:0] rd,
			input cwstk_pkg::depth_t dc, input logic uf);
		directed_row_t row;
		row.beat  = '{command: c, push_value: cwstk_pkg::word_t'(v), peek_offset: o};
		row.typed = typed;
		row.want  = '{read_data: cwstk_pkg::word_t'(rd), depth_count: dc, underflow: uf};
		directed_rows.push_back(row);
	endtask

	task automatic send_beat(input stack_cmd_t c, input bit typed, input stack_result_t want);
		stack_result_t predicted;
		while (!steady_flow && $urandom_range(99) < 25) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= c.command;
		req_ch.push_value  <= c.push_value;
		req_ch.peek_offset <= c.peek_offset;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = predict_stack_result(c);
		due_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		stack_result_t want;
		stack_result_t got;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = '{read_data: rsp_ch.read_data, depth_count: rsp_ch.depth_count,
				underflow: rsp_ch.underflow};
			if (due_results.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("Unexpected result beat: data %h depth %0d underflow %b",
						got.read_data, got.depth_count, got.underflow);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (got.read_data !== want.read_data || got.depth_count !== want.depth_count ||
						got.underflow !== want.underflow) begin
					if (mismatches < REPORT_LIMIT)
						$display({"Result %0d: expected data %h depth %0d underflow %b, ",
							"got data %h depth %0d underflow %b"},
							results_seen, want.read_data, want.depth_count, want.underflow,
							got.read_data, got.depth_count, got.underflow);
					mismatches++;
				end
			end
			results_seen++;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AT) begin
				hold_remaining = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_remaining != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_remaining--;
			end else if (steady_flow) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 25);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		stack_cmd_t c;
		cmd_mix_t   mix;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.command     = cwstk_pkg::CMD_QUERY;
		req_ch.push_value  = '0;
		req_ch.peek_offset = '0;
		foreach (model_ring[i]) model_ring[i] = '0;
		model_top   = '1;
		model_depth = '0;

		add_row(cwstk_pkg::CMD_POP,   32'h0,         6'h00, 1, 32'h0,         6'd0, 1'b1);
		add_row(cwstk_pkg::CMD_QUERY, 32'h0,         6'h00, 1, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_PUSH,  32'h7FFF_FFFF, 6'h00, 1, 32'h0,         6'd1, 1'b0);
		add_row(cwstk_pkg::CMD_PUSH,  32'h8000_0000, 6'h00, 1, 32'h0,         6'd2, 1'b0);
		add_row(cwstk_pkg::CMD_PEEK,  32'h0,         6'h00, 1, 32'h8000_0000, 6'd2, 1'b0);
		add_row(cwstk_pkg::CMD_PEEK,  32'h0,         6'h01, 1, 32'h7FFF_FFFF, 6'd2, 1'b0);
		add_row(cwstk_pkg::CMD_PEEK,  32'h0,         6'h3F, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_DUP,   32'h0,         6'h00, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_SWAP,  32'h0,         6'h00, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_PUSH,  32'h0,         6'h00, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_PUSH,  32'h5555_AAAA, 6'h00, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_SWAP,  32'h0,         6'h00, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_PEEK,  32'h0,         6'h2A, 0, 32'h0,         6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_PEEK,  32'h0,         6'h15, 0, 32'h0,         6'd0, 1'b0);
		add_row(CMD_SPARE_6,          32'hFFFF_FFFF, 6'h3F, 0, 32'h0,         6'd0, 1'b0);
		add_row(CMD_SPARE_7,          32'h0,         6'h00, 0, 32'h0,         6'd0, 1'b0);
		repeat (6) add_row(cwstk_pkg::CMD_POP, 32'h0, 6'h00, 0, 32'h0,       6'd0, 1'b0);
		add_row(cwstk_pkg::CMD_PEEK,  32'h0,         6'h00, 0, 32'h0,         6'd0, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i < 60) mix = MIX_EVEN;
			else if (i < 150) mix = MIX_PUSHES;
			else if (i < 190) mix = MIX_EVEN;
			else if (i < 280) mix = MIX_POPS;
			else if (i < 370) mix = MIX_PUSHES;
			else mix = MIX_EVEN;
			if (i == 280) drain_results();
			steady_flow <= (i >= 190 && i < 260);
			c.command     = pick_command(mix);
			c.push_value  = random_word();
			c.peek_offset = cwstk_pkg::offset_t'($urandom_range(63));
			send_beat(c, 1'b0, '0);
		end
		drain_results();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && due_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
